[rtl/core/itf_pkg.sv]
package itf_pkg;

  // default cap on field width and precision
  localparam int MAX_FIELD_DEF = 60;

  // digit slots: 22 octal digits cover 64 bits, the most of any radix
  localparam int DIG_SLOTS = 24;
  localparam int ND_W      = $clog2(DIG_SLOTS + 1);

  // radix selector codes (any other code means hexadecimal)
  localparam logic [1:0] RADIX_OCT = 2'd0;
  localparam logic [1:0] RADIX_DEC = 2'd1;
  localparam logic [1:0] RADIX_HEX = 2'd2;

  // format flag masks
  localparam logic [4:0] FMT_LEFT  = 5'd1;
  localparam logic [4:0] FMT_PLUS  = 5'd2;
  localparam logic [4:0] FMT_BLANK = 5'd4;
  localparam logic [4:0] FMT_ALT   = 5'd8;
  localparam logic [4:0] FMT_ZPAD  = 5'd16;

  // ascii codes
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_X     = 8'h78;
  localparam logic [7:0] CH_A     = 8'h41;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CONV,
    S_SCAN,
    S_SETUP,
    S_EMIT
  } fmt_state_t;

  // control from the sequencer to the digit unit
  typedef struct packed {
    logic start;   // load magnitude, clear digits
    logic dabble;  // one decimal conversion step
    logic unpack;  // split magnitude into octal or hex digits
    logic hex;     // unpack as hex when set, else octal
    logic shift;   // drop the top digit
  } dig_ctrl_t;

  // digit value to upper-case ascii
  function automatic logic [7:0] digit_char(input logic [3:0] d);
    logic [7:0] c;
    if (d < 4'd10) c = CH_ZERO + {4'h0, d};
    else           c = CH_A + {4'h0, d} - 8'd10;
    return c;
  endfunction

endpackage

[rtl/core/itf_digits.sv]
module itf_digits (
  input  logic              clk,
  input  itf_pkg::dig_ctrl_t ctrl,
  input  logic [63:0]       mag,
  output logic [3:0]        top_digit
);

  localparam int NS = itf_pkg::DIG_SLOTS;

  logic [63:0]         mag_r;
  logic [NS-1:0][3:0]  dig_r;
  logic [NS-1:0][3:0]  adj;
  logic [NS-1:0][3:0]  unp;
  logic [95:0]         mag_x;
  logic [NS*4:0]       dab;

  assign mag_x = {32'h0, mag_r};

  // add-3 correction per bcd digit, all digits at once
  always_comb begin
    for (int i = 0; i < NS; i++) begin
      adj[i] = (dig_r[i] >= 4'd5) ? dig_r[i] + 4'd3 : dig_r[i];
    end
  end

  // corrected digits shifted up by one bit, next magnitude bit in
  assign dab = {adj, mag_r[63]};

  // direct split for power-of-two radices
  always_comb begin
    for (int i = 0; i < NS; i++) begin
      if (ctrl.hex) unp[i] = mag_x[4*i +: 4];
      else          unp[i] = {1'b0, mag_x[3*i +: 3]};
    end
  end

  // magnitude and digit shift registers
  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      mag_r <= mag;
      dig_r <= '0;
    end else if (ctrl.dabble) begin
      dig_r <= dab[NS*4-1:0];
      mag_r <= {mag_r[62:0], 1'b0};
    end else if (ctrl.unpack) begin
      dig_r <= unp;
    end else if (ctrl.shift) begin
      dig_r <= {dig_r[NS-2:0], 4'h0};
    end
  end

  assign top_digit = dig_r[NS-1];

endmodule

[rtl/core/integer_to_text_formatter_core.sv]
// Formats one 64-bit integer per input word as printf-style text (octal, decimal or
// upper-case hex, with sign, alternate-form prefix, width, precision and padding flags)
// and sends it out one ascii character per output word, tlast on the final one; a
// number whose text is empty gives no output word. An item is accepted, then converted
// by bit-serial binary-to-bcd conversion for decimal (a direct split for octal or hex),
// leading zero digits are scanned off, a setup step follows, then one character per
// cycle (at most MAX_FIELD+3) goes out while the output is not stalled. The next
// word is taken as soon as the last character sits in the output register.
module integer_to_text_formatter_core #(
  parameter int MAX_FIELD = itf_pkg::MAX_FIELD_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // value[63:0], radix_sel[65:64], field_width[71:66], min_digits[78:72],
  // signed_conv[79], fmt_flags[84:80], zero[87:85]
  input  logic [87:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // out_char[7:0]
  output logic [7:0]  out_tdata,
  output logic        out_tlast
);

  localparam int CW = $clog2(MAX_FIELD + 4);
  localparam int NW = itf_pkg::ND_W;
  localparam logic [CW-1:0] MAXF = CW'(MAX_FIELD);

  // input fields
  logic [63:0] value;
  logic [1:0]  radix_sel;
  logic [5:0]  field_width;
  logic [6:0]  min_digits;
  logic        signed_conv;
  logic [4:0]  fmt_flags;

  assign value       = in_tdata[63:0];
  assign radix_sel   = in_tdata[65:64];
  assign field_width = in_tdata[71:66];
  assign min_digits  = in_tdata[78:72];
  assign signed_conv = in_tdata[79];
  assign fmt_flags   = in_tdata[84:80];

  itf_pkg::fmt_state_t state_r, state_nxt;

  logic [1:0]    radix_r;
  logic [CW-1:0] wid_r, prec_r;
  logic          has_sign_r;
  logic [7:0]    sign_ch_r;
  logic [1:0]    pre_len_r;
  logic          nodig_r, left_r, zpad_r;
  logic [5:0]    bit_r;
  logic [NW-1:0] nd_r;

  logic [CW-1:0] lead_r, zcnt_r, trail_r, cnt_r, dcnt_r;
  logic [1:0]    pre_r;
  logic          sign_pend_r;

  logic          out_tvalid_r, out_tlast_r;
  logic [7:0]    out_tdata_r;

  itf_pkg::dig_ctrl_t dctl;
  logic [3:0]    top_digit;
  logic          accept, emit_go;

  // decoded input spec
  logic          neg_in, is_hex_in, zero_in, given_in;
  logic [63:0]   mag_in;
  logic [CW-1:0] wid_in, prec_in;

  assign accept    = in_tvalid && in_tready;
  assign in_tready = (state_r == itf_pkg::S_IDLE);
  assign neg_in    = signed_conv && value[63];
  assign mag_in    = neg_in ? (64'd0 - value) : value;
  assign is_hex_in = (radix_sel != itf_pkg::RADIX_OCT) && (radix_sel != itf_pkg::RADIX_DEC);
  assign zero_in   = (value == 64'd0);
  assign given_in  = !min_digits[6];
  assign wid_in    = (int'(field_width) > MAX_FIELD) ? MAXF : CW'(field_width);
  assign prec_in   = !given_in ? '0 :
                     (int'(min_digits[5:0]) > MAX_FIELD) ? MAXF : CW'(min_digits[5:0]);

  itf_digits u_digits (
    .clk       (clk),
    .ctrl      (dctl),
    .mag       (mag_in),
    .top_digit (top_digit)
  );

  // setup arithmetic
  logic [CW-1:0] nd_ext, zeros_c, body_c, pad_c, total_c;
  assign nd_ext  = CW'(nd_r);
  assign zeros_c = (prec_r > nd_ext) ? prec_r - nd_ext : '0;
  assign body_c  = CW'(has_sign_r) + CW'(pre_len_r) + zeros_c + nd_ext;
  assign pad_c   = (wid_r > body_c) ? wid_r - body_c : '0;
  assign total_c = pad_c + body_c;

  assign emit_go = !out_tvalid_r || out_tready;

  // character pick for the emit state
  logic [7:0] ch_c;
  always_comb begin
    if (lead_r != '0)       ch_c = itf_pkg::CH_SPACE;
    else if (sign_pend_r)   ch_c = sign_ch_r;
    else if (pre_r != 2'd0) ch_c = (pre_r == 2'd1 && pre_len_r == 2'd2) ? itf_pkg::CH_X
                                                                         : itf_pkg::CH_ZERO;
    else if (zcnt_r != '0)  ch_c = itf_pkg::CH_ZERO;
    else if (dcnt_r != '0)  ch_c = itf_pkg::digit_char(top_digit);
    else                    ch_c = itf_pkg::CH_SPACE;
  end

  // next state and digit unit control
  always_comb begin
    state_nxt   = state_r;
    dctl        = '0;
    dctl.hex    = (radix_r != itf_pkg::RADIX_OCT);
    case (state_r)
      itf_pkg::S_IDLE: begin
        if (accept) begin
          dctl.start = 1'b1;
          state_nxt  = itf_pkg::S_CONV;
        end
      end
      itf_pkg::S_CONV: begin
        if (radix_r == itf_pkg::RADIX_DEC) begin
          dctl.dabble = 1'b1;
          if (bit_r == 6'd63) state_nxt = itf_pkg::S_SCAN;
        end else begin
          dctl.unpack = 1'b1;
          state_nxt   = itf_pkg::S_SCAN;
        end
      end
      itf_pkg::S_SCAN: begin
        if (!nodig_r && nd_r > NW'(1) && top_digit == 4'h0) dctl.shift = 1'b1;
        else state_nxt = itf_pkg::S_SETUP;
      end
      itf_pkg::S_SETUP: begin
        state_nxt = (total_c == '0) ? itf_pkg::S_IDLE : itf_pkg::S_EMIT;
      end
      itf_pkg::S_EMIT: begin
        if (emit_go) begin
          if (lead_r == '0 && !sign_pend_r && pre_r == 2'd0 && zcnt_r == '0 &&
              dcnt_r != '0) dctl.shift = 1'b1;
          if (cnt_r == CW'(1)) state_nxt = itf_pkg::S_IDLE;
        end
      end
      default: state_nxt = itf_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= itf_pkg::S_IDLE;
    else        state_r <= state_nxt;
  end

  // spec capture, conversion counters and segment counters
  always_ff @(posedge clk) begin
    if (accept) begin
      radix_r    <= is_hex_in ? itf_pkg::RADIX_HEX : radix_sel;
      wid_r      <= wid_in;
      prec_r     <= prec_in;
      has_sign_r <= neg_in || (signed_conv && (fmt_flags & (itf_pkg::FMT_PLUS |
                    itf_pkg::FMT_BLANK)) != 5'd0);
      sign_ch_r  <= neg_in ? itf_pkg::CH_MINUS :
                    ((fmt_flags & itf_pkg::FMT_PLUS) != 5'd0) ? itf_pkg::CH_PLUS
                                                              : itf_pkg::CH_SPACE;
      pre_len_r  <= ((fmt_flags & itf_pkg::FMT_ALT) == 5'd0) ? 2'd0 :
                    is_hex_in ? 2'd2 :
                    (radix_sel == itf_pkg::RADIX_OCT && zero_in) ? 2'd1 : 2'd0;
      nodig_r    <= given_in && prec_in == '0 && zero_in;
      left_r     <= (fmt_flags & itf_pkg::FMT_LEFT) != 5'd0;
      zpad_r     <= (fmt_flags & itf_pkg::FMT_ZPAD) != 5'd0;
      bit_r      <= '0;
      nd_r       <= NW'(itf_pkg::DIG_SLOTS);
    end
    if (state_r == itf_pkg::S_CONV) bit_r <= bit_r + 6'd1;
    if (state_r == itf_pkg::S_SCAN) begin
      if (nodig_r) nd_r <= '0;
      else if (dctl.shift) nd_r <= nd_r - NW'(1);
    end
    if (state_r == itf_pkg::S_SETUP) begin
      lead_r      <= (!left_r && !zpad_r) ? pad_c : '0;
      sign_pend_r <= has_sign_r;
      pre_r       <= pre_len_r;
      zcnt_r      <= ((!left_r && zpad_r) ? pad_c : '0) + zeros_c;
      dcnt_r      <= nd_ext;
      trail_r     <= left_r ? pad_c : '0;
      cnt_r       <= total_c;
    end
    if (state_r == itf_pkg::S_EMIT && emit_go) begin
      cnt_r <= cnt_r - CW'(1);
      if (lead_r != '0)       lead_r <= lead_r - CW'(1);
      else if (sign_pend_r)   sign_pend_r <= 1'b0;
      else if (pre_r != 2'd0) pre_r <= pre_r - 2'd1;
      else if (zcnt_r != '0)  zcnt_r <= zcnt_r - CW'(1);
      else if (dcnt_r != '0)  dcnt_r <= dcnt_r - CW'(1);
      else                    trail_r <= trail_r - CW'(1);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (state_r == itf_pkg::S_EMIT && emit_go) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == itf_pkg::S_EMIT && emit_go) begin
      out_tdata_r <= ch_c;
      out_tlast_r <= (cnt_r == CW'(1));
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tlast  = out_tlast_r;

  // segment counters always add up to the characters still owed
  a_seg_sum: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == itf_pkg::S_EMIT |->
      (CW+2)'(lead_r) + (CW+2)'(sign_pend_r) + (CW+2)'(pre_r) + (CW+2)'(zcnt_r) +
      (CW+2)'(dcnt_r) + (CW+2)'(trail_r) == (CW+2)'(cnt_r))
    else $error("segment counters disagree with remaining count");

  // emit never runs with nothing left to send
  a_emit_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == itf_pkg::S_EMIT |-> cnt_r != '0)
    else $error("emit state with zero characters left");

  // the last character word is followed by idle
  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == itf_pkg::S_EMIT && emit_go && cnt_r == CW'(1) |=>
      state_r == itf_pkg::S_IDLE && out_tvalid && out_tlast)
    else $error("last character not followed by idle");

  // digit count stays within the digit slots
  a_nd_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == itf_pkg::S_SETUP |-> int'(nd_r) <= itf_pkg::DIG_SLOTS)
    else $error("digit count out of range");

endmodule

[sim/integer_to_text_formatter_core_tb.sv]
`timescale 1ns / 100ps

module integer_to_text_formatter_core_tb;

  localparam int MAXF = itf_pkg::MAX_FIELD_DEF;

  typedef struct packed {
    logic [63:0] value;
    logic [1:0]  radix_sel;
    logic [5:0]  field_width;
    logic [6:0]  min_digits;
    logic        signed_conv;
    logic [4:0]  fmt_flags;
  } num_spec_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } text_char_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [87:0] in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [7:0]  out_tdata;
  logic        out_tlast;

  num_spec_t   spec_q[$];
  text_char_t  text_q[$];
  int          errors = 0;
  int          chars_seen = 0;
  int          numbers_sent = 0;
  int          send_idle_pct;
  int          recv_idle_pct;
  int          hold_cycles;
  bit          hold_req;
  bit          hold_taken;
  bit          drain_pause;

  integer_to_text_formatter_core dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tlast(out_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // fail-safe timeout
  initial begin
    #20ms;
    $display("[FAIL] regression broken");
    $finish;
  end

  function automatic void push_char(input logic [7:0] c);
    text_char_t t;
    t.ch = c;
    t.last = 1'b0;
    text_q.push_back(t);
  endfunction

  // expected text for one number
  function automatic void format_number(input num_spec_t s);
    logic [63:0] mag;
    logic [3:0]  digs[24];
    logic [7:0]  sign_ch;
    int radix, width, prec, nd, zeros, body, pad, pre_len, i, start;
    bit prec_given, neg, left, zpad;
    start = text_q.size();
    radix = (s.radix_sel == itf_pkg::RADIX_OCT) ? 8 :
            (s.radix_sel == itf_pkg::RADIX_DEC) ? 10 : 16;
    width = (int'(s.field_width) > MAXF) ? MAXF : int'(s.field_width);
    prec_given = !s.min_digits[6];
    prec = 0;
    if (prec_given) prec = (int'(s.min_digits) > MAXF) ? MAXF : int'(s.min_digits);
    neg = s.signed_conv && s.value[63];
    mag = neg ? 64'd0 - s.value : s.value;
    sign_ch = 8'h00;
    if (neg) sign_ch = itf_pkg::CH_MINUS;
    else if (s.signed_conv && (s.fmt_flags & itf_pkg::FMT_PLUS) != 5'd0)
      sign_ch = itf_pkg::CH_PLUS;
    else if (s.signed_conv && (s.fmt_flags & itf_pkg::FMT_BLANK) != 5'd0)
      sign_ch = itf_pkg::CH_SPACE;
    pre_len = 0;
    if ((s.fmt_flags & itf_pkg::FMT_ALT) != 5'd0) begin
      if (radix == 16) pre_len = 2;
      else if (radix == 8 && s.value == 64'd0) pre_len = 1;
    end
    nd = 0;
    if (!(prec_given && prec == 0 && s.value == 64'd0)) begin
      do begin
        digs[nd] = 4'(mag % 64'(radix));
        nd++;
        mag = mag / 64'(radix);
      end while (mag != 64'd0);
    end
    zeros = (prec_given && prec > nd) ? prec - nd : 0;
    body = int'(sign_ch != 8'h00) + pre_len + zeros + nd;
    pad = (width > body) ? width - body : 0;
    left = (s.fmt_flags & itf_pkg::FMT_LEFT) != 5'd0;
    zpad = (s.fmt_flags & itf_pkg::FMT_ZPAD) != 5'd0;
    if (!left && !zpad) for (i = 0; i < pad; i++) push_char(itf_pkg::CH_SPACE);
    if (sign_ch != 8'h00) push_char(sign_ch);
    if (pre_len >= 1) push_char(itf_pkg::CH_ZERO);
    if (pre_len == 2) push_char(itf_pkg::CH_X);
    if (!left && zpad) for (i = 0; i < pad; i++) push_char(itf_pkg::CH_ZERO);
    for (i = 0; i < zeros; i++) push_char(itf_pkg::CH_ZERO);
    for (i = nd - 1; i >= 0; i--) push_char(itf_pkg::digit_char(digs[i]));
    if (left) for (i = 0; i < pad; i++) push_char(itf_pkg::CH_SPACE);
    if (text_q.size() > start) text_q[text_q.size() - 1].last = 1'b1;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  function automatic num_spec_t make_spec(input logic [63:0] v, input logic [1:0] r,
                                          input logic [5:0] w, input logic [6:0] p,
                                          input logic sc, input logic [4:0] f);
    num_spec_t s;
    s.value = v; s.radix_sel = r; s.field_width = w;
    s.min_digits = p; s.signed_conv = sc; s.fmt_flags = f;
    return s;
  endfunction

  // mostly short widths and precisions, sometimes the full range
  function automatic num_spec_t rand_spec();
    num_spec_t s;
    s.value = {$urandom, $urandom};
    case ($urandom_range(0, 3))
      0: s.value = s.value >> $urandom_range(0, 63);
      1: s.value = 64'd0 - (s.value >> $urandom_range(0, 63));
      default: ;
    endcase
    s.radix_sel = 2'($urandom_range(0, 3));
    s.field_width = ($urandom_range(0, 9) == 0) ? 6'($urandom_range(0, 63))
                                                 : 6'($urandom_range(0, 24));
    case ($urandom_range(0, 4))
      0: s.min_digits = 7'h7F;
      1: s.min_digits = 7'($urandom_range(0, 127));
      default: s.min_digits = 7'($urandom_range(0, 24));
    endcase
    s.signed_conv = 1'($urandom_range(0, 1));
    s.fmt_flags = 5'($urandom_range(0, 31));
    return s;
  endfunction

  // sender: one word per handshake from the pending queue
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata  <= '0;
    end else if (!in_tvalid || in_tready) begin
      if (spec_q.size() > 0 && !drain_pause &&
          $urandom_range(0, 99) >= send_idle_pct) begin
        num_spec_t s;
        s = spec_q.pop_front();
        format_number(s);
        numbers_sent++;
        in_tvalid <= 1'b1;
        in_tdata  <= {3'b000, s.fmt_flags, s.signed_conv, s.min_digits,
                      s.field_width, s.radix_sel, s.value};
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // receiver stalls, with one long hold-off when requested
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready  <= 1'b0;
      hold_cycles <= 0;
      hold_taken  <= 1'b0;
    end else if (hold_req && !hold_taken) begin
      hold_taken  <= 1'b1;
      hold_cycles <= 2000;
      out_tready  <= 1'b0;
    end else if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_tready  <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // monitor: check each output word against the oldest expected char
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      chars_seen++;
      if (text_q.size() == 0) begin
        report_mismatch("unexpected char", int'(out_tdata), 0);
      end else begin
        text_char_t t;
        t = text_q.pop_front();
        if (out_tdata !== t.ch) report_mismatch("char", int'(out_tdata), int'(t.ch));
        if (out_tlast !== t.last) report_mismatch("last", int'(out_tlast), int'(t.last));
      end
    end
  end

  task automatic wait_drained();
    while (spec_q.size() > 0 || in_tvalid || text_q.size() > 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  initial begin
    int i;
    logic [63:0] min_neg;
    min_neg = 64'h8000_0000_0000_0000;
    rst_n = 1'b0;
    hold_req = 1'b0; drain_pause = 1'b0;
    send_idle_pct = 6; recv_idle_pct = 82;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // directed: extremes, every radix and flag, special cases
    spec_q.push_back(make_spec(0, itf_pkg::RADIX_DEC, 0, 7'd0, 1, 0));    // empty text
    spec_q.push_back(make_spec(0, itf_pkg::RADIX_OCT, 5, 7'd0, 0, itf_pkg::FMT_ALT));
    spec_q.push_back(make_spec(0, itf_pkg::RADIX_HEX, 6, 7'd0, 0, itf_pkg::FMT_ALT));
    spec_q.push_back(make_spec(min_neg, itf_pkg::RADIX_DEC, 0, 7'h7F, 1, 0)); // most negative
    spec_q.push_back(make_spec(min_neg, itf_pkg::RADIX_OCT, 0, 7'h7F, 0, 0));
    spec_q.push_back(make_spec('1, itf_pkg::RADIX_HEX, 63, 7'd127, 0, 5'h1F)); // saturation
    spec_q.push_back(make_spec('1, 2'd3, 20, 7'h7F, 1, itf_pkg::FMT_ALT)); // sel three
    spec_q.push_back(make_spec('1, itf_pkg::RADIX_DEC, 60, 7'd60, 0, itf_pkg::FMT_ZPAD));
    spec_q.push_back(make_spec(64'h7FFF_FFFF_FFFF_FFFF, itf_pkg::RADIX_DEC, 25, 7'h7F, 1,
                               itf_pkg::FMT_PLUS));
    spec_q.push_back(make_spec(42, itf_pkg::RADIX_DEC, 8, 7'h7F, 1, itf_pkg::FMT_BLANK));
    spec_q.push_back(make_spec(42, itf_pkg::RADIX_DEC, 8, 7'd4, 1,
                               itf_pkg::FMT_LEFT | itf_pkg::FMT_PLUS));
    spec_q.push_back(make_spec(-42, itf_pkg::RADIX_DEC, 8, 7'h7F, 1, itf_pkg::FMT_ZPAD));
    spec_q.push_back(make_spec(255, itf_pkg::RADIX_HEX, 10, 7'd4, 0,
                               itf_pkg::FMT_ALT | itf_pkg::FMT_ZPAD));
    spec_q.push_back(make_spec(255, itf_pkg::RADIX_HEX, 10, 7'h7F, 0,
                               itf_pkg::FMT_ALT | itf_pkg::FMT_LEFT | itf_pkg::FMT_ZPAD));
    spec_q.push_back(make_spec(8, itf_pkg::RADIX_OCT, 6, 7'd5, 1,
                               itf_pkg::FMT_ALT | itf_pkg::FMT_BLANK));
    spec_q.push_back(make_spec(0, itf_pkg::RADIX_DEC, 4, 7'd0, 1, itf_pkg::FMT_PLUS));
    spec_q.push_back(make_spec(7, itf_pkg::RADIX_DEC, 0, 7'h40, 0, 0)); // other negative prec
    wait_drained();

    // long receiver hold-off while the sender keeps offering
    for (i = 0; i < 8; i++) spec_q.push_back(rand_spec());
    hold_req = 1'b1;
    wait_drained();

    for (i = 0; i < 45; i++) spec_q.push_back(rand_spec());
    wait_drained();

    // sender pauses until all text is out
    drain_pause = 1'b1;
    wait_drained();
    drain_pause = 1'b0;

    send_idle_pct = 82; recv_idle_pct = 6;
    for (i = 0; i < 45; i++) spec_q.push_back(rand_spec());
    wait_drained();

    send_idle_pct = 0; recv_idle_pct = 0;
    for (i = 0; i < 45; i++) spec_q.push_back(rand_spec());
    wait_drained();

    $display("formatted %0d numbers into %0d characters across all radixes and flags",
             numbers_sent, chars_seen);
    $display("covered back-pressure, sender gaps and a full drain pause");
    if (errors == 0 && text_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/core/itf_pkg.sv
rtl/core/itf_digits.sv
rtl/core/integer_to_text_formatter_core.sv
sim/integer_to_text_formatter_core_tb.sv
